// ===== design/swmf_pkg.sv =====
`default_nettype none

package swmf_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CSR_W = 7;
   localparam logic [CSR_W-1:0] WINDOW_SIZE_RESET = 7'd3;

   // Broadcast from the controller to every cell of the sorted chain.
   typedef struct packed {
      logic                       load;
      logic                       drop;
      logic signed [SAMPLE_W-1:0] sample;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/swmf_cell.sv =====
`default_nettype none

module swmf_cell #(
   parameter int INDEX = 0,
   parameter int AW = 6,
   parameter int FW = 7
) (
   input  wire                                 clock,
   input  swmf_pkg::cell_ctrl_type             ctrl,
   input  wire  [FW-1:0]                       fill,
   input  wire  [AW-1:0]                       tag,
   input  wire  [AW-1:0]                       new_age,
   // left neighbor, after removal of the dropped entry
   input  wire  signed [swmf_pkg::SAMPLE_W-1:0] left_s_value,
   input  wire  [AW-1:0]                       left_s_age,
   input  wire                                 left_les,
   input  wire                                 left_dropa,
   // right neighbor, stored contents
   input  wire  signed [swmf_pkg::SAMPLE_W-1:0] right_value,
   input  wire  [AW-1:0]                       right_age,
   input  wire                                 right_le,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] value,
   output logic [AW-1:0]                       age,
   output logic                                le,
   output logic                                dropa,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] s_value,
   output logic [AW-1:0]                       s_age,
   output logic                                les
);

   logic signed [swmf_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [swmf_pkg::SAMPLE_W-1:0] value_in;
   logic [AW-1:0]                       age_ff;
   logic [AW-1:0]                       age_in;
   logic                                valid;
   logic                                match;

   always_comb begin
      valid = FW'(INDEX) < fill;
      // entry sits at or below the new sample in sorted order
      le = valid && !(ctrl.sample < value_ff);
      match = ctrl.drop && valid && (age_ff == tag);
      dropa = left_dropa || match;
      // view of the row with the oldest entry removed
      s_value = dropa ? right_value : value_ff;
      s_age = dropa ? right_age : age_ff;
      les = dropa ? right_le : le;
      // insert: keep, take the sample, or take the left neighbor
      if (les) begin
         value_in = s_value;
         age_in = s_age;
      end else if (left_les) begin
         value_in = ctrl.sample;
         age_in = new_age;
      end else begin
         value_in = left_s_value;
         age_in = left_s_age;
      end
      value = value_ff;
      age = age_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= value_in;
         age_ff <= age_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sliding_window_median_filter_unit.sv =====
// A full-window sample sets pending_ff; the median then goes to rsp_median_ff.
// Throughput: one sample per cycle while the result side keeps up; the sorted
// cell row inserts one sample and, once the window is full, drops the oldest.
// While a median is pending, a stalled result holds off samples until it is read.
// Reset (synchronous): empty window, window_size = 3, no result pending.
`default_nettype none

module sliding_window_median_filter_unit #(
   parameter int WINDOW_MAX = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  signed [swmf_pkg::SAMPLE_W-1:0] req_sample,
   input  wire                                  req_start_new,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] rsp_median,
   input  wire                                  csr_write_enable,
   input  wire  [swmf_pkg::CSR_W-1:0]           csr_write_data
);

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FW = $clog2(WINDOW_MAX + 1);
   localparam int WIDE = (FW > swmf_pkg::CSR_W) ? FW : swmf_pkg::CSR_W;

   logic [swmf_pkg::CSR_W-1:0]          window_size_ff;
   logic [FW-1:0]                       fill_ff;
   logic [FW-1:0]                       fill_in;
   logic [AW-1:0]                       ptr_ff;
   logic [AW-1:0]                       ptr_in;
   logic                                pending_ff;
   logic                                rsp_valid_ff;
   logic signed [swmf_pkg::SAMPLE_W-1:0] rsp_median_ff;

   logic [WIDE-1:0]                     ws_wide;
   logic [FW-1:0]                       k_eff;
   logic [FW:0]                         k_ext;
   logic [FW:0]                         p_ext;
   logic [FW:0]                         tag_full;
   logic [FW:0]                         mid_full;
   logic [AW-1:0]                       mid_idx;
   logic [AW-1:0]                       tag;
   logic [FW-1:0]                       fill_start;
   logic [AW-1:0]                       ptr_start;
   logic [FW-1:0]                       fill_after;
   logic                                accept;
   logic                                has_result;
   logic                                load_out;
   swmf_pkg::cell_ctrl_type             ctrl;

   logic signed [swmf_pkg::SAMPLE_W-1:0] c_value [WINDOW_MAX];
   logic [AW-1:0]                       c_age [WINDOW_MAX];
   logic                                c_le [WINDOW_MAX];
   logic                                c_dropa [WINDOW_MAX];
   logic signed [swmf_pkg::SAMPLE_W-1:0] c_s_value [WINDOW_MAX];
   logic [AW-1:0]                       c_s_age [WINDOW_MAX];
   logic                                c_les [WINDOW_MAX];

   always_comb begin
      ws_wide = WIDE'(window_size_ff);
      if (ws_wide == '0) begin
         k_eff = FW'(1);
      end else if (ws_wide > WIDE'(WINDOW_MAX)) begin
         k_eff = FW'(WINDOW_MAX);
      end else begin
         k_eff = ws_wide[FW-1:0];
      end
      k_ext = {1'b0, k_eff};
      mid_full = ((k_ext + (FW+1)'(1)) >> 1) - (FW+1)'(1);
      mid_idx = mid_full[AW-1:0];

      fill_start = req_start_new ? '0 : fill_ff;
      ptr_start = req_start_new ? '0 : ptr_ff;

      // arrival tag of the oldest sample, modulo WINDOW_MAX
      p_ext = (FW+1)'(ptr_start);
      if (p_ext >= k_ext) begin
         tag_full = p_ext - k_ext;
      end else begin
         tag_full = p_ext + (FW+1)'(WINDOW_MAX) - k_ext;
      end
      tag = tag_full[AW-1:0];

      load_out = pending_ff && (!rsp_valid_ff || !rsp_stall);
      // cells must hold until the median is copied out
      req_stall = pending_ff && !load_out;

      accept = req_valid && !req_stall;
      ctrl.drop = fill_start >= k_eff;
      ctrl.load = accept;
      ctrl.sample = req_sample;
      fill_after = ctrl.drop ? fill_start : fill_start + FW'(1);
      has_result = fill_after == k_eff;

      if (ptr_start == AW'(WINDOW_MAX - 1)) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_start + AW'(1);
      end
      fill_in = fill_after;
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic signed [swmf_pkg::SAMPLE_W-1:0] l_s_value;
      logic [AW-1:0]                       l_s_age;
      logic                                l_les;
      logic                                l_dropa;
      logic signed [swmf_pkg::SAMPLE_W-1:0] r_value;
      logic [AW-1:0]                       r_age;
      logic                                r_le;

      if (i == 0) begin : g_first
         assign l_s_value = req_sample;
         assign l_s_age = ptr_start;
         assign l_les = 1'b1;
         assign l_dropa = 1'b0;
      end else begin : g_mid_l
         assign l_s_value = c_s_value[i-1];
         assign l_s_age = c_s_age[i-1];
         assign l_les = c_les[i-1];
         assign l_dropa = c_dropa[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign r_value = c_value[i];
         assign r_age = c_age[i];
         assign r_le = 1'b0;
      end else begin : g_mid_r
         assign r_value = c_value[i+1];
         assign r_age = c_age[i+1];
         assign r_le = c_le[i+1];
      end

      swmf_cell #(
         .INDEX (i),
         .AW    (AW),
         .FW    (FW)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .fill         (fill_start),
         .tag          (tag),
         .new_age      (ptr_start),
         .left_s_value (l_s_value),
         .left_s_age   (l_s_age),
         .left_les     (l_les),
         .left_dropa   (l_dropa),
         .right_value  (r_value),
         .right_age    (r_age),
         .right_le     (r_le),
         .value        (c_value[i]),
         .age          (c_age[i]),
         .le           (c_le[i]),
         .dropa        (c_dropa[i]),
         .s_value      (c_s_value[i]),
         .s_age        (c_s_age[i]),
         .les          (c_les[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swmf_pkg::WINDOW_SIZE_RESET;
         fill_ff <= '0;
         ptr_ff <= '0;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_size_ff <= csr_write_data;
            fill_ff <= '0;
            ptr_ff <= '0;
         end else if (accept) begin
            fill_ff <= fill_in;
            ptr_ff <= ptr_in;
         end

         if (accept && has_result) begin
            pending_ff <= 1'b1;
         end else if (load_out) begin
            pending_ff <= 1'b0;
         end

         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_median_ff <= c_value[mid_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= k_eff)
      else $error("window fill exceeds window length");

   a_result_pending: assert property (@(posedge clock) disable iff (reset)
      accept && has_result |=> pending_ff)
      else $error("full-window transaction left no pending result");

   a_hold_cells: assert property (@(posedge clock) disable iff (reset)
      pending_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("sample accepted before median was read out");

endmodule

`default_nettype wire
